// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OTQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otq assertion failed");

// Next-cycle implication.
`define OTQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otq assertion failed");

`endif

// ===== hw/rtl/otq_pkg.sv =====
// ----------------------------------------------------------------------------
// otq_pkg
// Shared constants and types of the ordered timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int SLOTS_DEF = 32;
    localparam logic [31:0] ROLL_WINDOW_RST = 32'd3600000;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_EXPIRE  = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        sub;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] res;
        logic        borrow;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/ordered_timer_queue.sv =====
// ----------------------------------------------------------------------------
// ordered_timer_queue
// Cancel and refresh act on the addressed slot alone; add first searches for a free slot.
// Add, reset, query and expire each run a front scan over all slots; expire adds
// a due scan and, per reported slot, a further scan for the earliest pending slot.
// Scans walk the slots one by one through the shared 64-bit adder and the one read port of the deadline RAM.
// Reset clears all valid marks, the notice flag and the time; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_timer_queue #(
    parameter int SLOTS = otq_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [5:0]  slot_id,
    input  logic [31:0] period_ms,
    input  logic        repeat_req,
    input  logic        start_now,
    input  logic [63:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  result_slot,
    output logic        ok,
    output logic [63:0] delay_ms,
    output logic        front_notice,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] rollover_window_ms
);
    import otq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [6:0] SLOT_LIM = 7'(SLOTS);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ADD_SCAN = 5'd1;
    localparam logic [4:0] S_ADD_WR   = 5'd2;
    localparam logic [4:0] S_CAN      = 5'd3;
    localparam logic [4:0] S_READ     = 5'd4;
    localparam logic [4:0] S_REF      = 5'd5;
    localparam logic [4:0] S_RST1     = 5'd6;
    localparam logic [4:0] S_RST2     = 5'd7;
    localparam logic [4:0] S_SCAN     = 5'd8;
    localparam logic [4:0] S_NOTICE   = 5'd9;
    localparam logic [4:0] S_EXP0     = 5'd10;
    localparam logic [4:0] S_ROLL1    = 5'd11;
    localparam logic [4:0] S_ROLL2    = 5'd12;
    localparam logic [4:0] S_EXP_PEND = 5'd13;
    localparam logic [4:0] S_EXP_CHK  = 5'd14;
    localparam logic [4:0] S_EXP_SEL  = 5'd15;
    localparam logic [4:0] S_EXP_RD   = 5'd16;
    localparam logic [4:0] S_EXP_ARM  = 5'd17;
    localparam logic [4:0] S_QRY      = 5'd18;
    localparam logic [4:0] S_EMIT     = 5'd19;

    logic [4:0]       state_reg, state_next, after_reg, after_next, ret_reg, ret_next;
    logic [2:0]       op_reg, op_next;
    logic [31:0]      per_reg, per_next;
    logic             rep_reg, rep_next, fnow_reg, fnow_next, bad_reg, bad_next;
    logic [63:0]      now_reg, now_next;
    logic [IW-1:0]    tgt_reg, tgt_next, idx_reg, idx_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    logic             phase_reg, phase_next, found_reg, found_next;
    logic             pend_mode_reg, pend_mode_next;
    logic [63:0]      best_reg, best_next, acc_reg, acc_next;
    logic             flag_reg, flag_next, roll_reg, roll_next;
    logic [SLOTS-1:0] valid_reg, valid_next, repeat_reg, repeat_next;
    logic [SLOTS-1:0] pending_reg, pending_next, tgt_bit;
    logic [63:0]      prev_reg, prev_next;
    logic             tickled_reg, tickled_next;
    logic [31:0]      window_reg, window_next;
    logic [5:0]       res_slot_reg, res_slot_next;
    logic             res_ok_reg, res_ok_next, res_notice_reg, res_notice_next;
    logic             res_last_reg, res_last_next;
    logic [63:0]      res_delay_reg, res_delay_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       out_slot_reg, out_slot_next;
    logic             out_ok_reg, out_ok_next, out_notice_reg, out_notice_next;
    logic             out_last_reg, out_last_next;
    logic [63:0]      out_delay_reg, out_delay_next;

    logic             out_free, scan_hit, notice;
    logic [IW-1:0]    raddr;
    logic             we_per, we_dl;
    logic [31:0]      rd_per;
    logic [63:0]      rd_dl;
    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;

    otq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_per_ram (
        .clk   (clk),
        .we    (we_per),
        .waddr (tgt_reg),
        .wdata (per_reg),
        .raddr (raddr),
        .rdata (rd_per)
    );

    otq_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_dl_ram (
        .clk   (clk),
        .we    (we_dl),
        .waddr (tgt_reg),
        .wdata (alu_rsp.res),
        .raddr (raddr),
        .rdata (rd_dl)
    );

    otq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign result_slot  = out_slot_reg;
    assign ok           = out_ok_reg;
    assign delay_ms     = out_delay_reg;
    assign front_notice = out_notice_reg;
    assign last         = out_last_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign raddr    = (state_reg == S_SCAN || state_reg == S_EXP_PEND) ? idx_reg : tgt_reg;
    assign tgt_bit  = SLOTS'(1) << tgt_reg;
    assign scan_hit = (pend_mode_reg ? pending_reg[idx_reg] : valid_reg[idx_reg])
                      && (!found_reg || alu_rsp.borrow);
    assign notice   = found_reg && (best_idx_reg == tgt_reg) && !tickled_reg;

    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_SCAN:
            begin
                alu_req = '{a: rd_dl, b: best_reg, sub: 1'b1};
            end
            S_EXP_PEND:
            begin
                alu_req = '{a: now_reg, b: rd_dl, sub: 1'b1};
            end
            S_ADD_WR:
            begin
                alu_req = '{a: now_reg, b: {32'd0, per_reg}, sub: 1'b0};
            end
            S_REF, S_EXP_ARM:
            begin
                alu_req = '{a: now_reg, b: {32'd0, rd_per}, sub: 1'b0};
            end
            S_RST1:
            begin
                alu_req = '{a: rd_dl, b: {32'd0, rd_per}, sub: 1'b1};
            end
            S_RST2:
            begin
                alu_req = '{a: (fnow_reg ? now_reg : acc_reg), b: {32'd0, per_reg}, sub: 1'b0};
            end
            S_ROLL1:
            begin
                alu_req = '{a: prev_reg, b: now_reg, sub: 1'b1};
            end
            S_ROLL2:
            begin
                alu_req = '{a: {32'd0, window_reg}, b: acc_reg, sub: 1'b1};
            end
            S_QRY:
            begin
                alu_req = '{a: best_reg, b: now_reg, sub: 1'b1};
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        per_next        = per_reg;
        rep_next        = rep_reg;
        fnow_next       = fnow_reg;
        bad_next        = bad_reg;
        now_next        = now_reg;
        tgt_next        = tgt_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        phase_next      = phase_reg;
        found_next      = found_reg;
        pend_mode_next  = pend_mode_reg;
        best_next       = best_reg;
        acc_next        = acc_reg;
        flag_next       = flag_reg;
        roll_next       = roll_reg;
        valid_next      = valid_reg;
        repeat_next     = repeat_reg;
        pending_next    = pending_reg;
        prev_next       = prev_reg;
        tickled_next    = tickled_reg;
        window_next     = cfg_valid ? rollover_window_ms : window_reg;
        res_slot_next   = res_slot_reg;
        res_ok_next     = res_ok_reg;
        res_notice_next = res_notice_reg;
        res_last_next   = res_last_reg;
        res_delay_next  = res_delay_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_ok_next     = out_ok_reg;
        out_notice_next = out_notice_reg;
        out_last_next   = out_last_reg;
        out_delay_next  = out_delay_reg;
        we_per          = 1'b0;
        we_dl           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    per_next        = period_ms;
                    rep_next        = repeat_req;
                    fnow_next       = start_now;
                    now_next        = now_ms;
                    tgt_next        = slot_id[IW-1:0];
                    bad_next        = {1'b0, slot_id} >= SLOT_LIM;
                    res_slot_next   = '0;
                    res_ok_next     = 1'b0;
                    res_notice_next = 1'b0;
                    res_last_next   = 1'b1;
                    res_delay_next  = '0;
                    ret_next        = S_IDLE;
                    idx_next        = '0;
                    phase_next      = 1'b0;
                    found_next      = 1'b0;
                    pend_mode_next  = 1'b0;
                    case (opcode)
                        OP_ADD:
                        begin
                            state_next = S_ADD_SCAN;
                        end
                        OP_CANCEL:
                        begin
                            state_next = S_CAN;
                        end
                        OP_REFRESH, OP_RESET:
                        begin
                            state_next = S_READ;
                        end
                        OP_EXPIRE:
                        begin
                            state_next = S_SCAN;
                            after_next = S_EXP0;
                        end
                        OP_QUERY:
                        begin
                            tickled_next = 1'b0;
                            state_next   = S_SCAN;
                            after_next   = S_QRY;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_ADD_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    tgt_next   = idx_reg;
                    state_next = S_ADD_WR;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_ADD_WR:
            begin
                we_per               = 1'b1;
                we_dl                = 1'b1;
                valid_next[tgt_reg]  = 1'b1;
                repeat_next[tgt_reg] = rep_reg;
                res_slot_next        = 6'(tgt_reg);
                idx_next             = '0;
                state_next           = S_SCAN;
                after_next           = S_NOTICE;
            end
            S_CAN:
            begin
                if (!bad_reg && valid_reg[tgt_reg])
                begin
                    valid_next[tgt_reg] = 1'b0;
                    res_ok_next         = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_READ:
            begin
                if (bad_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (op_reg == OP_REFRESH)
                begin
                    state_next = valid_reg[tgt_reg] ? S_REF : S_EMIT;
                end
                else
                begin
                    state_next = S_RST1;
                end
            end
            S_REF:
            begin
                we_dl       = 1'b1;
                res_ok_next = 1'b1;
                state_next  = S_EMIT;
            end
            S_RST1:
            begin
                if (rd_per == per_reg && !fnow_reg)
                begin
                    res_ok_next = 1'b1;
                    state_next  = S_EMIT;
                end
                else if (!valid_reg[tgt_reg])
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    acc_next   = alu_rsp.res;
                    state_next = S_RST2;
                end
            end
            S_RST2:
            begin
                we_per     = 1'b1;
                we_dl      = 1'b1;
                idx_next   = '0;
                state_next = S_SCAN;
                after_next = S_NOTICE;
            end
            S_SCAN:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (scan_hit)
                    begin
                        best_next     = rd_dl;
                        best_idx_next = idx_reg;
                        found_next    = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = after_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_NOTICE:
            begin
                if (notice)
                begin
                    tickled_next = 1'b1;
                end
                res_notice_next = notice;
                res_ok_next     = 1'b1;
                state_next      = S_EMIT;
            end
            S_EXP0:
            begin
                state_next = found_reg ? S_ROLL1 : S_EMIT;
            end
            S_ROLL1:
            begin
                acc_next   = alu_rsp.res;
                flag_next  = !alu_rsp.borrow && (alu_rsp.res != '0);
                state_next = S_ROLL2;
            end
            S_ROLL2:
            begin
                roll_next  = flag_reg && alu_rsp.borrow;
                prev_next  = now_reg;
                idx_next   = '0;
                phase_next = 1'b0;
                state_next = S_EXP_PEND;
            end
            S_EXP_PEND:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    pending_next[idx_reg] = valid_reg[idx_reg] && (roll_reg || !alu_rsp.borrow);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_EXP_CHK;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_EXP_CHK:
            begin
                if (pending_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next       = '0;
                    phase_next     = 1'b0;
                    found_next     = 1'b0;
                    pend_mode_next = 1'b1;
                    after_next     = S_EXP_SEL;
                    state_next     = S_SCAN;
                end
            end
            S_EXP_SEL:
            begin
                tgt_next   = best_idx_reg;
                state_next = S_EXP_RD;
            end
            S_EXP_RD:
            begin
                state_next = S_EXP_ARM;
            end
            S_EXP_ARM:
            begin
                pending_next = pending_reg & ~tgt_bit;
                if (repeat_reg[tgt_reg])
                begin
                    we_dl = 1'b1;
                end
                else
                begin
                    valid_next[tgt_reg] = 1'b0;
                end
                res_slot_next = 6'(tgt_reg);
                res_ok_next   = 1'b1;
                res_last_next = (pending_reg & ~tgt_bit) == '0;
                ret_next      = ((pending_reg & ~tgt_bit) == '0) ? S_IDLE : S_SCAN;
                idx_next      = '0;
                phase_next    = 1'b0;
                found_next    = 1'b0;
                state_next    = S_EMIT;
            end
            S_QRY:
            begin
                if (!found_reg)
                begin
                    res_delay_next = '1;
                end
                else
                begin
                    res_ok_next    = 1'b1;
                    res_delay_next = alu_rsp.borrow ? 64'd0 : alu_rsp.res;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_ok_next     = res_ok_reg;
                    out_notice_next = res_notice_reg;
                    out_last_next   = res_last_reg;
                    out_delay_next  = res_delay_reg;
                    state_next      = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            repeat_reg    <= '0;
            pending_reg   <= '0;
            prev_reg      <= '0;
            tickled_reg   <= 1'b0;
            window_reg    <= ROLL_WINDOW_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            repeat_reg    <= repeat_next;
            pending_reg   <= pending_next;
            prev_reg      <= prev_next;
            tickled_reg   <= tickled_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        after_reg      <= after_next;
        ret_reg        <= ret_next;
        op_reg         <= op_next;
        per_reg        <= per_next;
        rep_reg        <= rep_next;
        fnow_reg       <= fnow_next;
        bad_reg        <= bad_next;
        now_reg        <= now_next;
        tgt_reg        <= tgt_next;
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        phase_reg      <= phase_next;
        found_reg      <= found_next;
        pend_mode_reg  <= pend_mode_next;
        best_reg       <= best_next;
        acc_reg        <= acc_next;
        flag_reg       <= flag_next;
        roll_reg       <= roll_next;
        res_slot_reg   <= res_slot_next;
        res_ok_reg     <= res_ok_next;
        res_notice_reg <= res_notice_next;
        res_last_reg   <= res_last_next;
        res_delay_reg  <= res_delay_next;
        out_slot_reg   <= out_slot_next;
        out_ok_reg     <= out_ok_next;
        out_notice_reg <= out_notice_next;
        out_last_reg   <= out_last_next;
        out_delay_reg  <= out_delay_next;
    end

endmodule

// ===== hw/rtl/otq_ram.sv =====
// ----------------------------------------------------------------------------
// otq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module otq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/otq_alu.sv =====
// ----------------------------------------------------------------------------
// otq_alu
// Shared 64-bit adder and subtractor; the borrow flags a < b on subtraction.
// ----------------------------------------------------------------------------
module otq_alu (
    input  otq_pkg::alu_req_t req,
    output otq_pkg::alu_rsp_t rsp
);
    import otq_pkg::*;

    logic [64:0] full;

    always_comb
    begin
        if (req.sub)
        begin
            full = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            full = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res    = full[63:0];
        rsp.borrow = req.sub & full[64];
    end

endmodule

// ===== hw/rtl/otq_checker.sv =====
// ----------------------------------------------------------------------------
// otq_checker
// Port-level checks of the ordered timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  result_slot,
    input logic        ok,
    input logic [63:0] delay_ms,
    input logic        front_notice
);

    `OTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `OTQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `OTQ_ASSERT_IMPL(a_notice_ok, clk, rst_n, out_valid && front_notice, ok)
    `OTQ_ASSERT_IMPL(a_delay_no_slot, clk, rst_n, out_valid && delay_ms != 64'd0,
                     result_slot == 6'd0 && !front_notice)

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (.*);
